// File: hdl/dpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and constants of the demand paging translator.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Request codes carried on req_type.
  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] byte_t;
  typedef logic [COUNT_W-1:0]       count_t;

endpackage
`default_nettype wire

// File: hdl/dpt_byte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_byte_ram
// Byte-wide RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dpt_byte_ram #(
  parameter int unsigned AW = 16
) (
  input  wire logic           clk_i,
  input  wire logic           wr_en_i,
  input  wire logic [AW-1:0]  wr_addr_i,
  input  wire dpt_pkg::byte_t wr_data_i,
  input  wire logic           rd_en_i,
  input  wire logic [AW-1:0]  rd_addr_i,
  output dpt_pkg::byte_t      rd_data_o
);
  import dpt_pkg::*;

  byte_t mem [2**AW];
  byte_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// File: hdl/demand_paging_translator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_translator_unit
// Demand paging address translator with page table, backing store and
// physical memory, and a sequencer that copies one page on each fault.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries req_type_i, address_i and
//   data_byte_i. A load beat (req_type 0) writes one backing store byte and
//   produces no result. A translate beat produces one result beat on the
//   output channel (out_valid_o / out_ready_i). A translate that hits passes
//   through the lookup and result steps to the result register. A fault runs
//   the lookup, copy, drain, fetch and result steps: the page copy moves one
//   byte per cycle through the single backing store read port and the single
//   physical memory write port; the offset counter drives the read and a
//   registered copy of it drives the write. The block works on one item at a
//   time; in_ready_o is high only when the sequencer is idle.
//   After reset the page table is cleared one entry per cycle; no item is
//   accepted until it is clear.
//   The result sits in an output register. While the receiver stalls, load
//   beats and a new translate are still taken; a second result waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module demand_paging_translator_unit #(
  parameter int unsigned OFFSET_BITS      = 8,
  parameter int unsigned PAGE_NUMBER_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           req_type_i,
  input  wire dpt_pkg::addr_t address_i,
  input  wire dpt_pkg::byte_t data_byte_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dpt_pkg::addr_t      virtual_addr_o,
  output dpt_pkg::addr_t      physical_addr_o,
  output dpt_pkg::byte_t      read_value_o,
  output logic                page_fault_o,
  output dpt_pkg::count_t     faults_so_far_o
);
  import dpt_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned PB = PAGE_NUMBER_BITS;
  localparam int unsigned FB = (ADDR_W - OB > 8) ? 8 : ADDR_W - OB;
  localparam int unsigned PA_W = FB + OB;
  localparam int unsigned PT_W = FB + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [PB-1:0] clr_q, clr_d;
  addr_t         addr_q, addr_d;
  logic          fault_q, fault_d;
  logic [FB-1:0] frame_q, frame_d;
  logic [FB-1:0] next_free_q, next_free_d;
  logic [OB-1:0] cnt_q, cnt_d;
  logic [OB-1:0] wr_off_q, wr_off_d;
  logic          wr_pend_q, wr_pend_d;
  count_t        faults_q, faults_d;

  logic          out_valid_q, out_valid_d;
  addr_t         out_vaddr_q;
  addr_t         out_paddr_q;
  byte_t         out_rdata_q;
  logic          out_fault_q;
  count_t        out_count_q;
  logic          out_load;

  // Page table: valid bit on top of the frame number.
  logic [PT_W-1:0] ptab [2**PB];
  logic [PT_W-1:0] pt_rd_q;
  logic            pt_rd_en;
  logic            pt_wr_en;
  logic [PB-1:0]   pt_wr_addr;
  logic [PT_W-1:0] pt_wr_data;

  logic            in_accept;
  logic [PB-1:0]   page_in;
  logic [PB-1:0]   page_q;
  logic [OB-1:0]   offset_q;
  logic            pt_hit;
  logic [FB-1:0]   pt_frame;
  addr_t           src_base;

  logic            bs_rd_en;
  addr_t           bs_rd_addr;
  byte_t           bs_rd_data;

  logic            pm_wr_en;
  logic [PA_W-1:0] pm_wr_addr;
  logic            pm_rd_en;
  logic [FB-1:0]   pm_rd_frame;
  logic [PA_W-1:0] pm_rd_addr;
  byte_t           pm_rd_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign page_in  = PB'(address_i >> OB);
  assign page_q   = PB'(addr_q >> OB);
  assign offset_q = addr_q[OB-1:0];
  assign pt_hit   = pt_rd_q[PT_W-1];
  assign pt_frame = pt_rd_q[FB-1:0];
  assign src_base = ADDR_W'({page_q, {OB{1'b0}}});

  assign out_load = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    fault_d     = fault_q;
    frame_d     = frame_q;
    next_free_d = next_free_q;
    cnt_d       = cnt_q;
    wr_off_d    = wr_off_q;
    wr_pend_d   = wr_pend_q;
    faults_d    = faults_q;
    pt_rd_en    = 1'b0;
    pt_wr_en    = 1'b0;
    pt_wr_addr  = page_q;
    pt_wr_data  = {1'b1, next_free_q};
    bs_rd_en    = 1'b0;
    pm_wr_en    = 1'b0;
    pm_rd_en    = 1'b0;
    pm_rd_frame = frame_q;

    unique case (state_q)
      S_CLEAR: begin
        pt_wr_en   = 1'b1;
        pt_wr_addr = clr_q;
        pt_wr_data = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == {PB{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept && (req_type_i == REQ_TRANSLATE)) begin
          pt_rd_en = 1'b1;
          addr_d   = address_i;
          state_d  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (pt_hit) begin
          fault_d     = 1'b0;
          frame_d     = pt_frame;
          pm_rd_en    = 1'b1;
          pm_rd_frame = pt_frame;
          state_d     = S_RESULT;
        end else begin
          fault_d     = 1'b1;
          frame_d     = next_free_q;
          next_free_d = next_free_q + 1'b1;
          if (faults_q != COUNT_MAX) begin
            faults_d = faults_q + 1'b1;
          end
          pt_wr_en  = 1'b1;
          cnt_d     = '0;
          wr_pend_d = 1'b0;
          state_d   = S_COPY;
        end
      end
      S_COPY: begin
        // Read one store byte per cycle, write the previous one.
        bs_rd_en  = 1'b1;
        pm_wr_en  = wr_pend_q;
        wr_off_d  = cnt_q;
        wr_pend_d = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == {OB{1'b1}}) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        pm_wr_en  = 1'b1;
        wr_pend_d = 1'b0;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        pm_rd_en = 1'b1;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign bs_rd_addr = src_base | ADDR_W'(cnt_q);
  assign pm_wr_addr = {frame_q, wr_off_q};
  assign pm_rd_addr = {pm_rd_frame, offset_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fault_q     <= 1'b0;
      next_free_q <= '0;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fault_q     <= fault_d;
      next_free_q <= next_free_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    frame_q  <= frame_d;
    wr_off_q <= wr_off_d;
    if (out_load) begin
      out_vaddr_q <= addr_q;
      out_paddr_q <= ADDR_W'({frame_q, offset_q});
      out_rdata_q <= pm_rd_data;
      out_fault_q <= fault_q;
      out_count_q <= faults_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_wr_en) begin
      ptab[pt_wr_addr] <= pt_wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_rd_en) begin
      pt_rd_q <= ptab[page_in];
    end
  end

  dpt_byte_ram #(
    .AW(ADDR_W)
  ) u_backing_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && (req_type_i == REQ_LOAD)),
    .wr_addr_i (address_i),
    .wr_data_i (data_byte_i),
    .rd_en_i   (bs_rd_en),
    .rd_addr_i (bs_rd_addr),
    .rd_data_o (bs_rd_data)
  );

  dpt_byte_ram #(
    .AW(PA_W)
  ) u_phys_mem (
    .clk_i     (clk_i),
    .wr_en_i   (pm_wr_en),
    .wr_addr_i (pm_wr_addr),
    .wr_data_i (bs_rd_data),
    .rd_en_i   (pm_rd_en),
    .rd_addr_i (pm_rd_addr),
    .rd_data_o (pm_rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign virtual_addr_o  = out_vaddr_q;
  assign physical_addr_o = out_paddr_q;
  assign read_value_o    = out_rdata_q;
  assign page_fault_o    = out_fault_q;
  assign faults_so_far_o = out_count_q;

  // A faulting result always carries a nonzero fault count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && page_fault_o) |-> (faults_so_far_o != '0))
    else $error("fault reported with zero fault count");

  // A translate beat blocks the input until its result is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_TRANSLATE)) |=> !in_ready_o)
    else $error("input taken again right after a translate");

  // A new result only comes out of the result step of the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESULT))
    else $error("result appeared outside the result step");

endmodule
`default_nettype wire
